@@ sv/usf_pkg.sv @@
// Package for the UDP socket steering filter.
// Holds the payload structs, command and status structs, and frame constants.
// No dependencies; the other files of the block, all but usf_ram, refer to it by scoped name.
package usf_pkg;

  // Table geometry and queue count.
  localparam int TableEntries = 64;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int QueueCount   = 64;

  // Frame byte position counter.
  localparam int          PosW        = 6;
  localparam logic [5:0]  PosMax      = 6'd63;
  localparam int          MinFrameLen = 42;

  // Fixed byte offsets of the captured header fields.
  localparam logic [5:0] PosEthHi   = 6'd12;
  localparam logic [5:0] PosEthLo   = 6'd13;
  localparam logic [5:0] PosProto   = 6'd23;
  localparam logic [5:0] PosDst0    = 6'd30;
  localparam logic [5:0] PosDst1    = 6'd31;
  localparam logic [5:0] PosDst2    = 6'd32;
  localparam logic [5:0] PosDst3    = 6'd33;
  localparam logic [5:0] PosPortHi  = 6'd36;
  localparam logic [5:0] PosPortLo  = 6'd37;

  // Header values tested by the classifier.
  localparam logic [15:0] EthertypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [31:0] AddrAny       = 32'h0000_0000;

  // Table entry layout in the RAM: address above port.
  localparam int EntryW = 48;

  // Input item kinds.
  typedef enum logic {
    KindFrame = 1'b0,
    KindWrite = 1'b1
  } kind_e;

  // One input item.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [5:0]  queue_index;
    logic [5:0]  entry_index;
    logic [31:0] entry_ip;
    logic [15:0] entry_port;
    logic        entry_valid;
  } in_t;

  // One result item.
  typedef struct packed {
    logic       verdict;
    logic [5:0] out_queue;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic walk_init;
    logic walk_run;
    logic emit_pass;
    logic emit_walk;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_last;
    logic eligible;
    logic walk_done;
  } status_t;

endpackage

@@ sv/usf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters; no package dependency.
module usf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/usf_ctrl.sv @@
// Controller of the UDP socket steering filter: accepts items and sequences
// the table walk. Depends on usf_pkg for the command and status structs.
module usf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output usf_pkg::cmd_t    cmd_o,
  input  usf_pkg::status_t status_i
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWalk = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    case (state_q)
      StIdle: begin
        cmd_o.accept = start_i;
        if (status_i.frame_last) begin
          if (status_i.eligible) begin
            cmd_o.walk_init = 1'b1;
            state_d         = StWalk;
          end else begin
            cmd_o.emit_pass = 1'b1;
          end
        end
      end
      StWalk: begin
        cmd_o.walk_run = 1'b1;
        if (status_i.walk_done) begin
          cmd_o.emit_walk = 1'b1;
          state_d         = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

@@ sv/usf_dp.sv @@
// Datapath of the UDP socket steering filter: header capture, bound-address
// table with valid bits, walk compare and result register.
// Depends on usf_pkg and instantiates usf_ram.
module usf_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  usf_pkg::in_t      in_i,
  input  logic              cfg_we_i,
  input  logic [63:0]       cfg_wdata_i,
  input  usf_pkg::cmd_t     cmd_i,
  output usf_pkg::status_t  status_o,
  output logic              result_valid_o,
  output usf_pkg::out_t     result_o
);

  localparam int IdxW = usf_pkg::IdxW;

  logic [63:0]                        mask_q;
  logic [usf_pkg::PosW-1:0]           pos_q, pos_d;
  logic [15:0]                        eth_q, eth_d;
  logic [7:0]                         proto_q, proto_d;
  logic [31:0]                        dst_q, dst_d;
  logic [15:0]                        port_q, port_d;
  logic [31:0]                        key_addr_q;
  logic [15:0]                        key_port_q;
  logic [5:0]                         qidx_q;
  logic                               bound_q;
  logic                               bound_d;
  logic [usf_pkg::TableEntries-1:0]   valid_q;
  logic [IdxW-1:0]                    rd_addr_q;
  logic [IdxW-1:0]                    cmp_idx_q;
  logic                               cmp_vld_q;
  logic                               hit_q;
  logic                               match;
  logic [usf_pkg::EntryW-1:0]         rdata;
  logic [31:0]                        ent_addr;
  logic [15:0]                        ent_port;
  logic                               frame_acc;
  logic                               write_acc;
  logic                               write_in_range;
  logic [IdxW-1:0]                    waddr;
  logic                               res_valid_q;
  usf_pkg::out_t                      res_q;

  assign frame_acc = cmd_i.accept && (in_i.kind == usf_pkg::KindFrame);
  assign write_acc = cmd_i.accept && (in_i.kind == usf_pkg::KindWrite);
  assign write_in_range = ({1'b0, in_i.entry_index} < 7'(usf_pkg::TableEntries));
  assign waddr = IdxW'(in_i.entry_index);

  // Configuration register: socket-present bit per receive queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_we_i) begin
      mask_q <= cfg_wdata_i;
    end
  end

  // Header capture at fixed offsets; the current byte is folded in here.
  always_comb begin
    eth_d   = eth_q;
    proto_d = proto_q;
    dst_d   = dst_q;
    port_d  = port_q;
    if (pos_q inside {usf_pkg::PosEthHi, usf_pkg::PosEthLo}) begin
      eth_d = {eth_q[7:0], in_i.data_byte};
    end
    if (pos_q == usf_pkg::PosProto) begin
      proto_d = in_i.data_byte;
    end
    if (pos_q inside {usf_pkg::PosDst0, usf_pkg::PosDst1,
                      usf_pkg::PosDst2, usf_pkg::PosDst3}) begin
      dst_d = {dst_q[23:0], in_i.data_byte};
    end
    if (pos_q inside {usf_pkg::PosPortHi, usf_pkg::PosPortLo}) begin
      port_d = {port_q[7:0], in_i.data_byte};
    end
  end

  // Byte position saturates; it returns to zero after the last byte.
  always_comb begin
    pos_d = pos_q;
    if (frame_acc) begin
      if (in_i.last) begin
        pos_d = '0;
      end else if (pos_q < usf_pkg::PosMax) begin
        pos_d = pos_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  // Captured header bytes, cleared at reset and after the last byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eth_q   <= '0;
      proto_q <= '0;
      dst_q   <= '0;
      port_q  <= '0;
    end else if (frame_acc) begin
      if (in_i.last) begin
        eth_q   <= '0;
        proto_q <= '0;
        dst_q   <= '0;
        port_q  <= '0;
      end else begin
        eth_q   <= eth_d;
        proto_q <= proto_d;
        dst_q   <= dst_d;
        port_q  <= port_d;
      end
    end
  end

  // Frame end status toward the controller.
  assign status_o.frame_last = frame_acc && in_i.last;
  assign status_o.eligible   = (pos_q >= 6'(usf_pkg::MinFrameLen - 1))
                            && (eth_d == usf_pkg::EthertypeIpv4)
                            && (proto_d == usf_pkg::ProtoUdp);

  // Lookup key and queue are latched on the last byte.
  assign bound_d = ({1'b0, in_i.queue_index} < 7'(usf_pkg::QueueCount))
                && mask_q[in_i.queue_index];

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      key_addr_q <= dst_d;
      key_port_q <= port_d;
      qidx_q     <= in_i.queue_index;
      bound_q    <= bound_d;
    end
  end

  // Valid bit per table slot, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (write_acc && write_in_range) begin
      valid_q[waddr] <= in_i.entry_valid;
    end
  end

  // Address and port of each slot.
  usf_ram #(
    .Width (usf_pkg::EntryW),
    .Depth (usf_pkg::TableEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (write_acc && write_in_range),
    .waddr_i (waddr),
    .wdata_i ({in_i.entry_ip, in_i.entry_port}),
    .re_i    (cmd_i.walk_run),
    .raddr_i (rd_addr_q),
    .rdata_o (rdata)
  );

  assign ent_addr = rdata[47:16];
  assign ent_port = rdata[15:0];

  // A slot hits on an exact address or on the any-address wildcard.
  assign match = cmp_vld_q && valid_q[cmp_idx_q] && (ent_port == key_port_q)
              && ((ent_addr == key_addr_q) || (ent_addr == usf_pkg::AddrAny));

  // Table walk: one read issued and one slot compared per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_addr_q <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (cmd_i.walk_init) begin
      rd_addr_q <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
    end else if (cmd_i.walk_run) begin
      rd_addr_q <= rd_addr_q + IdxW'(1);
      cmp_vld_q <= 1'b1;
      if (match) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_run) begin
      cmp_idx_q <= rd_addr_q;
    end
  end

  assign status_o.walk_done = cmp_vld_q && (cmp_idx_q == IdxW'(usf_pkg::TableEntries - 1));

  // Result register, shown for one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_pass || cmd_i.emit_walk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pass) begin
      res_q <= '0;
    end else if (cmd_i.emit_walk) begin
      res_q.verdict   <= (hit_q || match) && bound_q;
      res_q.out_queue <= ((hit_q || match) && bound_q) ? qidx_q : 6'd0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

@@ sv/udp_socket_steering_filter.sv @@
// UDP socket steering filter, top level.
// Joins the controller (usf_ctrl) and the datapath (usf_dp); uses usf_pkg.
//
// Use: items enter on in_i with start_i, and a transfer takes place at a
// rising edge where start_i is high and busy_o is low. A frame byte item
// (kind frame) is taken every cycle while busy_o is low; a table write item
// (kind write) updates one slot at once, also in the middle of a frame.
// The queue mask is written through cfg_wdata_i with cfg_we_i; the user must
// write it only while idle, as the block itself does not enforce this. Each
// frame's last byte yields one result on result_o, marked by result_valid_o
// for exactly one cycle; the receiver cannot stall it. A frame that is short,
// not IPv4 or not UDP gets its pass verdict in the cycle after its last byte.
// A UDP frame starts a walk of the 64-entry table through the table RAM's
// single read port, one slot per cycle; busy_o stays high during the walk and
// the result appears in the same cycle that busy_o is low again.
// Reset clears every slot's valid bit, the queue mask, the captured header
// fields and the byte position; the block is ready as soon as reset is
// released.
module udp_socket_steering_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  usf_pkg::in_t  in_i,
  input  logic          cfg_we_i,
  input  logic [63:0]   cfg_wdata_i,
  output logic          result_valid_o,
  output usf_pkg::out_t result_o
);

  usf_pkg::cmd_t    cmd;
  usf_pkg::status_t status;

  // Sequencing of item transfers and the table walk.
  usf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd),
    .status_i (status)
  );

  // Capture, table storage, compare and result.
  usf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_i           (in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
